### hdl/abp_pkg.sv
// Shared constants, box type and overlap test for the AABB broadphase block.
`default_nettype none
package abp_pkg;

	// Store sizing
	localparam int MAX_BOXES  = 32;
	localparam int IDX_W      = $clog2(MAX_BOXES);
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);

	// Result sizing
	localparam int RESULT_CAP = 32;
	localparam int CAP_W      = $clog2(RESULT_CAP + 1);
	localparam int OUT_IDX_W  = 5;

	// Coordinates are signed Q16.16
	localparam int COORD_W    = 32;

	// Operation codes
	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_ADD   = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	// Touching faces count as overlap on every axis
	function automatic logic boxes_overlap(box_t a, box_t b);
		logic sep_x;
		logic sep_y;
		logic sep_z;
		sep_x = ($signed(a.min_x) > $signed(b.max_x)) || ($signed(b.min_x) > $signed(a.max_x));
		sep_y = ($signed(a.min_y) > $signed(b.max_y)) || ($signed(b.min_y) > $signed(a.max_y));
		sep_z = ($signed(a.min_z) > $signed(b.max_z)) || ($signed(b.min_z) > $signed(a.max_z));
		return !(sep_x || sep_y || sep_z);
	endfunction

endpackage
`default_nettype wire

### hdl/abp_cell.sv
// One cell of the box chain: holds one stored box and tests the passing probe.
`default_nettype none
module abp_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire abp_pkg::box_t  wr_box,
	input  wire abp_pkg::box_t  probe_in,
	input  wire                 token_in,
	input  wire                 enable,
	output abp_pkg::box_t       probe_out,
	output logic                token_out,
	output logic                hit
);

	abp_pkg::box_t store_q;
	abp_pkg::box_t probe_q;
	logic          token_q;

	// Load the stored box when this cell is the next free slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q <= wr_box;
		end
	end

	// Advance the probe one cell per cycle
	always_ff @(posedge clk) begin
		probe_q <= probe_in;
	end

	// Advance the token; drop it once the run has ended
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else begin
			token_q <= token_in & enable;
		end
	end

	assign hit       = token_q & abp_pkg::boxes_overlap(store_q, probe_q);
	assign probe_out = probe_q;
	assign token_out = token_q;

endmodule
`default_nettype wire

### hdl/aabb_broadphase_pairs.sv
// Top level of the all-pairs AABB broadphase: cell chain, run control and result register.
//
// A clear or a dropped add (store full) gives its single result in the cycle after the
// transfer and leaves busy low. An add that lands as box number n (n boxes already stored)
// sends its probe down the chain of cells, one cell per cycle, so busy stays high until
// the probe reaches cell n; the last result appears as busy drops, and the next item can
// be taken in that same cycle. Pairs come out in index order, at most one per cycle, each
// on the result ports for a single cycle marked by result_valid; the receiver cannot stall.
`default_nettype none
module aabb_broadphase_pairs (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire               operation,
	input  wire signed [31:0] min_x,
	input  wire signed [31:0] min_y,
	input  wire signed [31:0] min_z,
	input  wire signed [31:0] max_x,
	input  wire signed [31:0] max_y,
	input  wire signed [31:0] max_z,
	output logic              result_valid,
	output logic              pair_valid,
	output logic [4:0]        first_index,
	output logic [4:0]        second_index,
	output logic              store_full,
	output logic              last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	localparam int NB = abp_pkg::MAX_BOXES;
	localparam int IW = abp_pkg::IDX_W;
	localparam int CW = abp_pkg::CNT_W;
	localparam int OW = abp_pkg::OUT_IDX_W;

	logic                         state_q;
	logic [CW-1:0]                count_q;
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                pos_q;
	logic [abp_pkg::CAP_W-1:0]    found_q;
	logic                         pend_q;
	logic [IW-1:0]                pend_first_q;

	logic                         res_valid_q;
	logic                         res_pair_q;
	logic [OW-1:0]                res_first_q;
	logic [OW-1:0]                res_second_q;
	logic                         res_full_q;
	logic                         res_last_q;

	abp_pkg::box_t                new_box;
	abp_pkg::box_t                probe   [NB];
	logic          [NB-1:0]       token;
	logic          [NB-1:0]       hits;
	logic          [NB-1:0]       wr_en;
	logic                         launch;
	logic                         run_live;
	logic                         hit_any;
	logic                         at_end;

	assign new_box.min_x = min_x;
	assign new_box.min_y = min_y;
	assign new_box.min_z = min_z;
	assign new_box.max_x = max_x;
	assign new_box.max_y = max_y;
	assign new_box.max_z = max_z;

	assign busy     = (state_q == ST_RUN);
	assign launch   = (state_q == ST_IDLE) && start && (operation == abp_pkg::OP_ADD)
	                  && (count_q < CW'(NB));
	assign at_end   = (pos_q == idx_q);
	assign run_live = (state_q == ST_RUN) && !at_end;
	assign hit_any  = |hits;

	// Chain of cells; the probe and its token move one cell per cycle
	for (genvar i = 0; i < NB; i++) begin : g_cell
		assign wr_en[i] = launch && (count_q[IW-1:0] == IW'(i));
		if (i == 0) begin : g_head
			abp_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.wr_en     (wr_en[i]),
				.wr_box    (new_box),
				.probe_in  (new_box),
				.token_in  (launch),
				.enable    (1'b1),
				.probe_out (probe[i]),
				.token_out (token[i]),
				.hit       (hits[i])
			);
		end else begin : g_body
			abp_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.wr_en     (wr_en[i]),
				.wr_box    (new_box),
				.probe_in  (probe[i-1]),
				.token_in  (token[i-1]),
				.enable    (run_live),
				.probe_out (probe[i]),
				.token_out (token[i]),
				.hit       (hits[i])
			);
		end
	end

	// Run control, box count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			found_q      <= '0;
			pend_q       <= 1'b0;
			pend_first_q <= '0;
			res_valid_q  <= 1'b0;
			res_pair_q   <= 1'b0;
			res_first_q  <= '0;
			res_second_q <= '0;
			res_full_q   <= 1'b0;
			res_last_q   <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (operation == abp_pkg::OP_CLEAR) begin
							count_q      <= '0;
							res_valid_q  <= 1'b1;
							res_pair_q   <= 1'b0;
							res_first_q  <= '0;
							res_second_q <= '0;
							res_full_q   <= 1'b0;
							res_last_q   <= 1'b1;
						end else if (!launch) begin
							res_valid_q  <= 1'b1;
							res_pair_q   <= 1'b0;
							res_first_q  <= '0;
							res_second_q <= '0;
							res_full_q   <= 1'b1;
							res_last_q   <= 1'b1;
						end else begin
							idx_q   <= count_q[IW-1:0];
							count_q <= CW'(count_q + 1'b1);
							pos_q   <= '0;
							found_q <= '0;
							pend_q  <= 1'b0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (at_end) begin
						// Flush the held pair as last, or report no overlap
						res_valid_q  <= 1'b1;
						res_pair_q   <= pend_q;
						res_first_q  <= pend_q ? OW'(pend_first_q) : '0;
						res_second_q <= OW'(idx_q);
						res_full_q   <= 1'b0;
						res_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						// Hold each new pair until the next one is found, so the final one can carry last
						if (hit_any && (found_q != abp_pkg::CAP_W'(abp_pkg::RESULT_CAP))) begin
							if (pend_q) begin
								res_valid_q  <= 1'b1;
								res_pair_q   <= 1'b1;
								res_first_q  <= OW'(pend_first_q);
								res_second_q <= OW'(idx_q);
								res_full_q   <= 1'b0;
								res_last_q   <= 1'b0;
							end
							pend_q       <= 1'b1;
							pend_first_q <= pos_q;
							found_q      <= abp_pkg::CAP_W'(found_q + 1'b1);
						end
						pos_q <= IW'(pos_q + 1'b1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign pair_valid   = res_pair_q;
	assign first_index  = res_first_q;
	assign second_index = res_second_q;
	assign store_full   = res_full_q;
	assign last         = res_last_q;

	// At most one probe token in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token))
		else $error("more than one probe token in the cell chain");

	// A result without last is always a pair
	a_mid_is_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> pair_valid)
		else $error("non-final result without a pair");

	// A dropped add is a lone, pairless result
	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && store_full) |-> (last && !pair_valid))
		else $error("store-full result is not a lone final result");

	// Pairs name an earlier box
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && pair_valid) |-> (first_index < second_index))
		else $error("pair does not name an earlier stored box");

	// Count never exceeds the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NB))
		else $error("box count beyond store depth");

	// A launched probe reaches the head cell in the next cycle
	a_launch_token: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> (token[0] && busy))
		else $error("launched add did not enter the cell chain");

endmodule
`default_nettype wire
